[design/gwns_pkg.sv]
// Shared types and constants of the grid wavefront planner.
// No dependencies; imported by gwns_nbr, grid_wavefront_next_step and its testbench.

package gwns_pkg;

  // Fixed widths of the beat fields
  localparam int COORD_W    = 5;
  localparam int DIST_OUT_W = 11;

  // Largest distance the result field can carry
  localparam logic [DIST_OUT_W-1:0] DIST_MAX = 11'd2047;

  // Result status codes
  localparam logic [1:0] ST_WRITE    = 2'd0;
  localparam logic [1:0] ST_MOVE     = 2'd1;
  localparam logic [1:0] ST_ARRIVED  = 2'd2;
  localparam logic [1:0] ST_ENCLOSED = 2'd3;

  // Neighbor directions, in the tie-break order
  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_XM = 2'd1,
    DIR_YM = 2'd2,
    DIR_YP = 2'd3
  } dir_t;

endpackage

[design/grid_wavefront_next_step.sv]
// Grid wavefront planner top level: obstacle map, distance store, frontier
// queue and the sequencer around the shared neighbor unit. Uses gwns_pkg, gwns_nbr.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  request | req_valid | req_stall | mode cell_x cell_y blocked agent_x agent_y
//          |           |           | target_x target_y
//  result  | rsp_valid | rsp_stall | status next_x next_y agent_distance
//          |           |           | goal_x goal_y
//
// A map write is stored and answered straight from the idle state. A plan beat
// probes the goal cell and, if blocked, its neighbors, presets the distance store,
// floods out from the goal (per cell reached, one queue read plus four neighbor
// probes through the shared unit and the single map/distance read port), probes
// the agent cell and its neighbors and posts the result. An enclosed target
// answers straight after goal probing. After reset the obstacle map is swept
// free with req_stall high. The block holds one request at a time; a finished
// result waits in the output register while rsp_stall is high.

module grid_wavefront_next_step
  import gwns_pkg::*;
#(
  parameter int GRID_SIDE = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  mode,
  input  logic [COORD_W-1:0]    cell_x,
  input  logic [COORD_W-1:0]    cell_y,
  input  logic                  blocked,
  input  logic [COORD_W-1:0]    agent_x,
  input  logic [COORD_W-1:0]    agent_y,
  input  logic [COORD_W-1:0]    target_x,
  input  logic [COORD_W-1:0]    target_y,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [1:0]            status,
  output logic [COORD_W-1:0]    next_x,
  output logic [COORD_W-1:0]    next_y,
  output logic [DIST_OUT_W-1:0] agent_distance,
  output logic [COORD_W-1:0]    goal_x,
  output logic [COORD_W-1:0]    goal_y
);

  localparam int CW         = $clog2(GRID_SIDE);
  localparam int AW         = 2 * CW;
  localparam int DEPTH      = 1 << AW;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int DW         = $clog2(CELL_COUNT + 1);
  localparam logic [DW-1:0] UNREACHED = DW'(CELL_COUNT);

  typedef enum logic [10:0] {
    S_INIT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_GOAL  = 11'b000_0000_0100,
    S_DCLR  = 11'b000_0000_1000,
    S_SEED  = 11'b000_0001_0000,
    S_POP   = 11'b000_0010_0000,
    S_NB    = 11'b000_0100_0000,
    S_LAST  = 11'b000_1000_0000,
    S_AGENT = 11'b001_0000_0000,
    S_AEND  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  function automatic logic [CW-1:0] clamp(input logic [COORD_W-1:0] c);
    return (int'(c) >= GRID_SIDE) ? CW'(GRID_SIDE - 1) : CW'(c);
  endfunction

  function automatic logic [DIST_OUT_W-1:0] sat_dist(input logic [DW-1:0] d);
    return (int'(d) > int'(DIST_MAX)) ? DIST_MAX : DIST_OUT_W'(d);
  endfunction

  state_t          state;
  logic [AW-1:0]   cnt;
  logic [2:0]      k;
  logic            phase;
  logic [CW-1:0]   ag_x, ag_y, tg_x, tg_y, gl_x, gl_y, ctr_x, ctr_y;
  logic [AW:0]     head, tail, level_end;
  logic [DW-1:0]   cur_dist;
  logic            ev_valid, ev_self;
  logic [CW-1:0]   ev_x, ev_y;
  logic [DW-1:0]   ad, best;
  logic            have;
  logic [CW-1:0]   bx, by;
  logic            enclosed;

  // Memories and their registered read data
  logic            obs_mem  [DEPTH];
  logic [DW-1:0]   dist_mem [DEPTH];
  logic [AW-1:0]   q_mem    [DEPTH];
  logic            obs_rdata;
  logic [DW-1:0]   dist_rdata;
  logic [AW-1:0]   q_rdata;

  logic            obs_we, obs_wdata;
  logic [AW-1:0]   obs_waddr;
  logic            dist_we;
  logic [AW-1:0]   dist_waddr;
  logic [DW-1:0]   dist_wdata;
  logic            q_we;
  logic [AW-1:0]   q_waddr, q_wdata;

  logic            req_take, rsp_free, rsp_load, in_grid;
  logic [CW-1:0]   base_x, base_y, nbr_x, nbr_y, cand_x, cand_y;
  logic            nbr_ok, cand_ok;
  dir_t            probe_dir;
  logic [AW-1:0]   rd_addr;
  logic            push, pop_ok;
  logic [AW:0]     tail_next;
  logic [DW-1:0]   nd;

  // Handshake
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !rsp_free;
  assign in_grid   = (int'(cell_x) < GRID_SIDE) && (int'(cell_y) < GRID_SIDE);
  assign rsp_load  = (state == S_IDLE && req_take && !mode) ||
                     (state == S_DONE && rsp_free);

  // Probe select: probe 0 is the base cell, probes 1..4 its neighbors
  always_comb begin
    probe_dir = dir_t'(2'(k - 3'd1));
    if (state == S_GOAL) begin
      base_x = tg_x;
      base_y = tg_y;
    end else if (state == S_AGENT) begin
      base_x = ag_x;
      base_y = ag_y;
    end else if (k == 3'd1) begin
      base_x = q_rdata[AW-1:CW];
      base_y = q_rdata[CW-1:0];
    end else begin
      base_x = ctr_x;
      base_y = ctr_y;
    end
    cand_x  = (k == 3'd0) ? base_x : nbr_x;
    cand_y  = (k == 3'd0) ? base_y : nbr_y;
    cand_ok = (k == 3'd0) || nbr_ok;
  end

  gwns_nbr #(
    .GRID_SIDE (GRID_SIDE)
  ) u_nbr (
    .base_x (base_x),
    .base_y (base_y),
    .dir    (probe_dir),
    .nbr_x  (nbr_x),
    .nbr_y  (nbr_y),
    .nbr_ok (nbr_ok)
  );

  assign rd_addr = {cand_x, cand_y};

  // Flood evaluation of the probe issued in the previous cycle
  assign push      = (state == S_NB || state == S_LAST) && ev_valid &&
                     !obs_rdata && (dist_rdata == UNREACHED);
  assign tail_next = tail + (AW + 1)'(push);
  assign pop_ok    = (head != tail);
  assign nd        = cur_dist + DW'(1);

  // Memory write ports
  always_comb begin
    obs_we     = 1'b0;
    obs_waddr  = cnt;
    obs_wdata  = 1'b0;
    dist_we    = 1'b0;
    dist_waddr = cnt;
    dist_wdata = UNREACHED;
    q_we       = 1'b0;
    q_waddr    = tail[AW-1:0];
    q_wdata    = {ev_x, ev_y};
    if (state == S_INIT) begin
      obs_we = 1'b1;
    end else if (state == S_IDLE && req_take && !mode && in_grid) begin
      obs_we    = 1'b1;
      obs_waddr = {CW'(cell_x), CW'(cell_y)};
      obs_wdata = blocked;
    end
    if (state == S_DCLR) begin
      dist_we = 1'b1;
    end else if (state == S_SEED) begin
      dist_we    = 1'b1;
      dist_waddr = {gl_x, gl_y};
      dist_wdata = '0;
      q_we       = 1'b1;
      q_waddr    = '0;
      q_wdata    = {gl_x, gl_y};
    end else if (push) begin
      dist_we    = 1'b1;
      dist_waddr = {ev_x, ev_y};
      dist_wdata = nd;
      q_we       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (obs_we) obs_mem[obs_waddr] <= obs_wdata;
    obs_rdata <= obs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rdata <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[head[AW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      k         <= '0;
      phase     <= 1'b0;
      rsp_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      level_end <= '0;
      cur_dist  <= '0;
      ev_valid  <= 1'b0;
      ev_self   <= 1'b0;
      have      <= 1'b0;
      enclosed  <= 1'b0;
    end else begin
      // Load a finished result, drop it once it is taken
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;

      unique case (state) inside
        S_INIT: begin
          cnt <= cnt + AW'(1);
          if (&cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_take) begin
            if (!mode) begin
              status         <= ST_WRITE;
              next_x         <= '0;
              next_y         <= '0;
              agent_distance <= '0;
              goal_x         <= '0;
              goal_y         <= '0;
            end else begin
              ag_x     <= clamp(agent_x);
              ag_y     <= clamp(agent_y);
              tg_x     <= clamp(target_x);
              tg_y     <= clamp(target_y);
              k        <= '0;
              phase    <= 1'b0;
              enclosed <= 1'b0;
              state    <= S_GOAL;
            end
          end
        end
        S_GOAL: begin
          // For each candidate, issue the map read, then check its registered result
          if (!phase) begin
            ev_x     <= cand_x;
            ev_y     <= cand_y;
            ev_valid <= cand_ok;
            phase    <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (ev_valid && !obs_rdata) begin
              gl_x  <= ev_x;
              gl_y  <= ev_y;
              cnt   <= '0;
              state <= S_DCLR;
            end else if (k == 3'd4) begin
              enclosed <= 1'b1;
              ad       <= UNREACHED;
              gl_x     <= tg_x;
              gl_y     <= tg_y;
              state    <= S_DONE;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        S_DCLR: begin
          cnt <= cnt + AW'(1);
          if (&cnt) state <= S_SEED;
        end
        S_SEED: begin
          head      <= '0;
          tail      <= (AW + 1)'(1);
          level_end <= (AW + 1)'(1);
          cur_dist  <= '0;
          ev_valid  <= 1'b0;
          state     <= S_POP;
        end
        S_POP, S_LAST: begin
          tail     <= tail_next;
          ev_valid <= 1'b0;
          if (pop_ok) begin
            // Advance the head; a new level starts at the level mark
            head <= head + (AW + 1)'(1);
            if (head == level_end) begin
              cur_dist  <= cur_dist + DW'(1);
              level_end <= tail_next;
            end
            k     <= 3'd1;
            state <= S_NB;
          end else if (push) begin
            state <= S_POP;
          end else begin
            k     <= '0;
            state <= S_AGENT;
          end
        end
        S_NB: begin
          tail     <= tail_next;
          ev_valid <= cand_ok;
          ev_self  <= 1'b0;
          ev_x     <= cand_x;
          ev_y     <= cand_y;
          if (k == 3'd1) begin
            ctr_x <= q_rdata[AW-1:CW];
            ctr_y <= q_rdata[CW-1:0];
          end
          if (k == 3'd4) state <= S_LAST;
          else k <= k + 3'd1;
        end
        S_AGENT: begin
          ev_valid <= cand_ok;
          ev_self  <= (k == 3'd0);
          ev_x     <= cand_x;
          ev_y     <= cand_y;
          if (k == 3'd0) have <= 1'b0;
          if (k == 3'd4) state <= S_AEND;
          else k <= k + 3'd1;
        end
        S_AEND: begin
          ev_valid <= 1'b0;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            agent_distance <= sat_dist(ad);
            goal_x         <= COORD_W'(gl_x);
            goal_y         <= COORD_W'(gl_y);
            if (enclosed) begin
              status <= ST_ENCLOSED;
              next_x <= '0;
              next_y <= '0;
            end else if (ad == '0) begin
              status <= ST_ARRIVED;
              next_x <= COORD_W'(ag_x);
              next_y <= COORD_W'(ag_y);
            end else begin
              status <= ST_MOVE;
              next_x <= COORD_W'(bx);
              next_y <= COORD_W'(by);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase

      // Agent probes: keep the agent distance, then the first least neighbor
      if ((state == S_AGENT || state == S_AEND) && ev_valid) begin
        if (ev_self) begin
          ad <= dist_rdata;
        end else if (!have || dist_rdata < best) begin
          have <= 1'b1;
          best <= dist_rdata;
          bx   <= ev_x;
          by   <= ev_y;
        end
      end
    end
  end

  // Checks on the sequencer and the result
  a_write_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !mode) |=> (rsp_valid && status == ST_WRITE))
    else $error("map write beat did not produce a write result");

  a_arrived_dist: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_ARRIVED) |-> (agent_distance == '0))
    else $error("arrived result with nonzero distance");

  a_enclosed_next: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_ENCLOSED) |-> (next_x == '0 && next_y == '0))
    else $error("enclosed result carries a move");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_NB || state == S_LAST) |-> (head <= tail && level_end <= tail))
    else $error("frontier queue pointers out of order");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NB) |-> (cur_dist < UNREACHED))
    else $error("flood level reached the unreached marker");

endmodule

[design/gwns_nbr.sv]
// Shared neighbor step unit: one 4-connected neighbor of a base cell and
// whether it lies on the grid. Depends on gwns_pkg (dir_t).

module gwns_nbr
  import gwns_pkg::*;
#(
  parameter int GRID_SIDE = 32,
  localparam int CW = $clog2(GRID_SIDE)
) (
  input  logic [CW-1:0] base_x,
  input  logic [CW-1:0] base_y,
  input  dir_t          dir,
  output logic [CW-1:0] nbr_x,
  output logic [CW-1:0] nbr_y,
  output logic          nbr_ok
);

  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

  // Step one cell and flag steps that leave the grid
  always_comb begin
    nbr_x  = base_x;
    nbr_y  = base_y;
    nbr_ok = 1'b0;
    unique case (dir)
      DIR_XP: begin
        nbr_x  = base_x + CW'(1);
        nbr_ok = (base_x != LAST);
      end
      DIR_XM: begin
        nbr_x  = base_x - CW'(1);
        nbr_ok = (base_x != '0);
      end
      DIR_YM: begin
        nbr_y  = base_y - CW'(1);
        nbr_ok = (base_y != '0);
      end
      DIR_YP: begin
        nbr_y  = base_y + CW'(1);
        nbr_ok = (base_y != LAST);
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

endmodule

[test/grid_wavefront_next_step_test.sv]
// Self-checking testbench for the grid wavefront planner: map writes and plan beats
// are checked against an in-bench breadth-first planner.
// Depends on gwns_pkg and grid_wavefront_next_step.

module grid_wavefront_next_step_test
  import gwns_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE        = 32;
  localparam int CELLS       = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int BURST_LEN   = 12;
  localparam int RANDOM_LEN  = 104;
  localparam int LONG_HOLD   = 400;

  // One request beat; hold_for_drain marks a pause point, not a beat
  typedef struct packed {
    logic             mode;
    logic [4:0]       cell_x;
    logic [4:0]       cell_y;
    logic             blocked;
    logic [4:0]       agent_x;
    logic [4:0]       agent_y;
    logic [4:0]       target_x;
    logic [4:0]       target_y;
    bit               hold_for_drain;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [4:0]            next_x;
    logic [4:0]            next_y;
    logic [DIST_OUT_W-1:0] agent_distance;
    logic [4:0]            goal_x;
    logic [4:0]            goal_y;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic mode = 1'b0;
  logic [COORD_W-1:0] cell_x = '0;
  logic [COORD_W-1:0] cell_y = '0;
  logic blocked = 1'b0;
  logic [COORD_W-1:0] agent_x = '0;
  logic [COORD_W-1:0] agent_y = '0;
  logic [COORD_W-1:0] target_x = '0;
  logic [COORD_W-1:0] target_y = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [1:0] status;
  logic [COORD_W-1:0] next_x;
  logic [COORD_W-1:0] next_y;
  logic [DIST_OUT_W-1:0] agent_distance;
  logic [COORD_W-1:0] goal_x;
  logic [COORD_W-1:0] goal_y;

  req_beat_t    pending_reqs[$];
  step_result_t expected_steps[$];
  req_beat_t    cur_req;

  bit          wall_map [CELLS];
  int unsigned dist_map [CELLS];

  int sent_cnt = 0;
  int got_cnt = 0;
  int total_items = 0;
  int burst_mark = 0;
  int errors = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  grid_wavefront_next_step #(.GRID_SIDE(SIDE)) u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .cell_x(cell_x), .cell_y(cell_y), .blocked(blocked),
    .agent_x(agent_x), .agent_y(agent_y), .target_x(target_x), .target_y(target_y),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .next_x(next_x), .next_y(next_y),
    .agent_distance(agent_distance), .goal_x(goal_x), .goal_y(goal_y)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Step one cell in a direction; returns 0 off the edge of the map
  function automatic bit step_to(input int unsigned x, input int unsigned y, input dir_t dir,
                                 output int unsigned nx, output int unsigned ny);
    nx = x;
    ny = y;
    case (dir)
      DIR_XP: begin
        if (x + 1 >= SIDE) return 1'b0;
        nx = x + 1;
      end
      DIR_XM: begin
        if (x == 0) return 1'b0;
        nx = x - 1;
      end
      DIR_YM: begin
        if (y == 0) return 1'b0;
        ny = y - 1;
      end
      default: begin
        if (y + 1 >= SIDE) return 1'b0;
        ny = y + 1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic int unsigned sat_coord(input logic [4:0] c);
    return (int'(c) >= SIDE) ? SIDE - 1 : int'(c);
  endfunction

  // Apply a write or plan one step, updating the shadow obstacle map
  function automatic step_result_t plan_or_write(input req_beat_t b);
    step_result_t r;
    int unsigned ax, ay, tx, ty, gx, gy, ad, best, d, nx, ny, c, cx, cy, i, k;
    int unsigned wave[$];
    bit have, moved;
    r = '0;
    r.status = ST_WRITE;
    if (b.mode == 1'b0) begin
      if (b.cell_x < SIDE && b.cell_y < SIDE) wall_map[b.cell_x * SIDE + b.cell_y] = b.blocked;
      return r;
    end
    ax = sat_coord(b.agent_x);
    ay = sat_coord(b.agent_y);
    tx = sat_coord(b.target_x);
    ty = sat_coord(b.target_y);
    gx = tx;
    gy = ty;

    // relocate a blocked goal to its first free neighbor
    if (wall_map[gx * SIDE + gy]) begin
      moved = 1'b0;
      for (k = 0; k < 4 && !moved; k++) begin
        if (step_to(tx, ty, dir_t'(k), nx, ny) && !wall_map[nx * SIDE + ny]) begin
          gx = nx;
          gy = ny;
          moved = 1'b1;
        end
      end
      if (!moved) begin
        r.status = ST_ENCLOSED;
        r.agent_distance = DIST_OUT_W'((CELLS > DIST_MAX) ? DIST_MAX : CELLS);
        r.goal_x = 5'(tx);
        r.goal_y = 5'(ty);
        return r;
      end
    end

    // flood unit distances out from the goal
    for (i = 0; i < CELLS; i++) dist_map[i] = CELLS;
    dist_map[gx * SIDE + gy] = 0;
    wave.insert(wave.size(), gx * SIDE + gy);
    while (wave.size() != 0) begin
      c = wave.pop_front();
      cx = c / SIDE;
      cy = c % SIDE;
      for (k = 0; k < 4; k++) begin
        if (step_to(cx, cy, dir_t'(k), nx, ny) && !wall_map[nx * SIDE + ny] &&
            dist_map[nx * SIDE + ny] == CELLS) begin
          dist_map[nx * SIDE + ny] = dist_map[c] + 1;
          wave.insert(wave.size(), nx * SIDE + ny);
        end
      end
    end

    ad = dist_map[ax * SIDE + ay];
    r.agent_distance = DIST_OUT_W'((ad > DIST_MAX) ? DIST_MAX : ad);
    r.goal_x = 5'(gx);
    r.goal_y = 5'(gy);
    if (ad == 0) begin
      r.status = ST_ARRIVED;
      r.next_x = 5'(ax);
      r.next_y = 5'(ay);
      return r;
    end

    // pick the closest neighbor, first in order wins ties
    have = 1'b0;
    best = 0;
    for (k = 0; k < 4; k++) begin
      if (step_to(ax, ay, dir_t'(k), nx, ny)) begin
        d = dist_map[nx * SIDE + ny];
        if (!have || d < best) begin
          have = 1'b1;
          best = d;
          r.next_x = 5'(nx);
          r.next_y = 5'(ny);
        end
      end
    end
    r.status = ST_MOVE;
    return r;
  endfunction

  task automatic queue_write(input int x, input int y, input bit blk);
    req_beat_t b;
    b = '0;
    b.mode = 1'b0;
    b.cell_x = 5'(x);
    b.cell_y = 5'(y);
    b.blocked = blk;
    b.agent_x = 5'($urandom_range(31));
    b.agent_y = 5'($urandom_range(31));
    b.target_x = 5'($urandom_range(31));
    b.target_y = 5'($urandom_range(31));
    pending_reqs.insert(pending_reqs.size(), b);
    total_items++;
  endtask

  task automatic queue_plan(input int ax, input int ay, input int tx, input int ty);
    req_beat_t b;
    b = '0;
    b.mode = 1'b1;
    b.cell_x = 5'($urandom_range(31));
    b.cell_y = 5'($urandom_range(31));
    b.blocked = 1'($urandom_range(1));
    b.agent_x = 5'(ax);
    b.agent_y = 5'(ay);
    b.target_x = 5'(tx);
    b.target_y = 5'(ty);
    pending_reqs.insert(pending_reqs.size(), b);
    total_items++;
  endtask

  task automatic queue_drain();
    req_beat_t b;
    b = '0;
    b.hold_for_drain = 1'b1;
    pending_reqs.insert(pending_reqs.size(), b);
  endtask

  // Coordinate within two cells of a center, kept on the map
  function automatic int near(input int c);
    int v;
    v = c + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > SIDE - 1) v = SIDE - 1;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 60)
      $display("result %0d: %s got %0d want %0d", got_cnt, what, got, want);
  endtask

  // Build the stimulus, then wait for the last result and settle
  initial begin
    int n, pick, hot_x, hot_y;

    // open map: arrived, long moves with ties
    queue_plan(7, 7, 7, 7);
    queue_plan(31, 31, 0, 0);
    queue_plan(0, 0, 31, 31);
    // corner goal walled in, then one side reopened
    queue_write(0, 0, 1'b1);
    queue_write(1, 0, 1'b1);
    queue_write(0, 1, 1'b1);
    queue_plan(5, 5, 0, 0);
    queue_write(0, 1, 1'b0);
    queue_plan(0, 1, 0, 0);
    // interior goal relocated through each direction, then enclosed
    queue_write(10, 10, 1'b1);
    queue_plan(20, 3, 10, 10);
    queue_write(11, 10, 1'b1);
    queue_plan(11, 10, 10, 10);
    queue_write(9, 10, 1'b1);
    queue_plan(0, 31, 10, 10);
    queue_write(10, 9, 1'b1);
    queue_plan(10, 11, 10, 10);
    queue_write(10, 11, 1'b1);
    queue_plan(31, 0, 10, 10);
    // agent cut off from the goal
    queue_write(30, 0, 1'b1);
    queue_write(31, 1, 1'b1);
    queue_plan(31, 0, 15, 15);
    queue_write(31, 31, 1'b1);
    queue_write(31, 31, 1'b0);

    // pause for every result, then a write burst into a long receiver hold
    queue_drain();
    burst_mark = total_items;
    hot_x = $urandom_range(31);
    hot_y = $urandom_range(31);
    for (n = 0; n < BURST_LEN; n++) queue_write(near(hot_x), near(hot_y), $urandom_range(99) < 75);

    // random mix, clustered around a moving hot spot so goals hit walls
    for (n = 0; n < RANDOM_LEN; n++) begin
      if (n % 20 == 10) begin
        hot_x = $urandom_range(31);
        hot_y = $urandom_range(31);
      end
      pick = $urandom_range(99);
      if (pick < 50)
        queue_write(near(hot_x), near(hot_y), $urandom_range(99) < 75);
      else if (pick < 58)
        queue_write($urandom_range(31), $urandom_range(31), 1'($urandom_range(1)));
      else if (pick < 73)
        queue_plan($urandom_range(31), $urandom_range(31), near(hot_x), near(hot_y));
      else if (pick < 88)
        queue_plan(near(hot_x), near(hot_y), near(hot_x), near(hot_y));
      else
        queue_plan($urandom_range(31), $urandom_range(31), $urandom_range(31),
                   $urandom_range(31));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (got_cnt == total_items);
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("grid_wavefront_next_step regression: pass");
    else
      $display("grid_wavefront_next_step regression: fail");
    $finish;
  end

  // Drive request beats; predict each one as it is accepted
  always @(posedge clk) begin
    int issued;
    bit send_quiet;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      issued = sent_cnt;
      send_quiet = (sent_cnt >= 60 && sent_cnt < 90);
      if (req_valid) begin
        expected_steps.insert(expected_steps.size(), plan_or_write(cur_req));
        issued = issued + 1;
        sent_cnt <= issued;
      end
      // release a pause point once everything sent has answered
      if (pending_reqs.size() != 0 && pending_reqs[0].hold_for_drain && issued == got_cnt)
        void'(pending_reqs.pop_front());
      if (pending_reqs.size() == 0 || pending_reqs[0].hold_for_drain ||
          (!send_quiet && $urandom_range(99) < 7)) begin
        req_valid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        req_valid <= 1'b1;
        mode <= cur_req.mode;
        cell_x <= cur_req.cell_x;
        cell_y <= cur_req.cell_y;
        blocked <= cur_req.blocked;
        agent_x <= cur_req.agent_x;
        agent_y <= cur_req.agent_y;
        target_x <= cur_req.target_x;
        target_y <= cur_req.target_y;
      end
    end
  end

  // Stall the result side: random idling plus one long hold after the pause
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!hold_done && got_cnt == burst_mark) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !(got_cnt >= 60 && got_cnt < 90) && ($urandom_range(99) < 7);
    end
  end

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    step_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (got_cnt >= sent_cnt) begin
        report_mismatch("unexpected result, status", int'(status), 0);
      end else begin
        want = expected_steps.pop_front();
        if (status !== want.status)
          report_mismatch("status", int'(status), int'(want.status));
        if (next_x !== want.next_x)
          report_mismatch("next_x", int'(next_x), int'(want.next_x));
        if (next_y !== want.next_y)
          report_mismatch("next_y", int'(next_y), int'(want.next_y));
        if (agent_distance !== want.agent_distance)
          report_mismatch("agent_distance", int'(agent_distance), int'(want.agent_distance));
        if (goal_x !== want.goal_x)
          report_mismatch("goal_x", int'(goal_x), int'(want.goal_x));
        if (goal_y !== want.goal_y)
          report_mismatch("goal_y", int'(goal_y), int'(want.goal_y));
        got_cnt <= got_cnt + 1;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("grid_wavefront_next_step regression: fail");
      $finish;
    end
  end

endmodule
